FILE: rtl/tbf_pkg.sv
// Shared types, kernel weights and constant-division helpers for the 3x3 blur filter.
`default_nettype none
package tbf_pkg;

  localparam int TAPS = 9;
  localparam logic [7:0] BORDER_VALUE = 8'd255;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [2:0] GAUSS_W [TAPS] = '{3'd1, 3'd2, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd2, 3'd1};
  localparam logic [2:0] WEIGHT_W [TAPS] = '{3'd2, 3'd3, 3'd2, 3'd3, 3'd5, 3'd3, 3'd2, 3'd3, 3'd2};

  typedef struct packed {
    logic valid;
    logic full;
  } tbf_ctl_t;

  // floor(t / 9) for 8-bit t: t * 57 >> 9
  function automatic logic [4:0] div9(input logic [7:0] t);
    logic [13:0] p;
    p = 14'(t) * 14'd57;
    return p[13:9];
  endfunction

  // floor(x / 25) for x <= 1275: x * 1311 >> 15
  function automatic logic [5:0] div25(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1311;
    return p[20:15];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tbf_kernel.sv
// Two-stage kernel: per-tap weighted terms, then the three sums with border substitution.
`default_nettype none
module tbf_kernel
  import tbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire tbf_ctl_t   in_ctl,
  input  wire logic [7:0] taps [TAPS],
  output tbf_ctl_t        out_ctl,
  output logic [7:0]      box_value,
  output logic [7:0]      gauss_value,
  output logic [7:0]      weighted_value
);

  tbf_ctl_t   term_ctl;
  logic [4:0] box_term   [TAPS];
  logic [5:0] gauss_term [TAPS];
  logic [5:0] wt_term    [TAPS];
  logic [7:0] box_sum;
  logic [7:0] gauss_sum;
  logic [7:0] wt_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_ctl <= '0;
    end else if (en) begin
      term_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TAPS; k++) begin
        logic [10:0] gp;
        logic [10:0] wp;
        gp = 11'(taps[k]) * 11'(GAUSS_W[k]);
        wp = 11'(taps[k]) * 11'(WEIGHT_W[k]);
        box_term[k]   <= div9(taps[k]);
        gauss_term[k] <= gp[9:4];
        wt_term[k]    <= div25(wp);
      end
    end
  end

  always_comb begin
    box_sum   = '0;
    gauss_sum = '0;
    wt_sum    = '0;
    for (int k = 0; k < TAPS; k++) begin
      box_sum   = box_sum + 8'(box_term[k]);
      gauss_sum = gauss_sum + 8'(gauss_term[k]);
      wt_sum    = wt_sum + 8'(wt_term[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl <= term_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_value      <= term_ctl.full ? box_sum   : BORDER_VALUE;
      gauss_value    <= term_ctl.full ? gauss_sum : BORDER_VALUE;
      weighted_value <= term_ctl.full ? wt_sum    : BORDER_VALUE;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/triple_3x3_blur_filter.sv
// Top level of the streaming 3x3 box, binomial and weighted blur filter.
// Takes one pixel per clock in raster order unless m_tready stalls it, and returns one
// result per pixel, registered in turn by the line-store read, the window register and
// the kernel's term and sum stages. The line stores are one memory of MAX_WIDTH entries,
// read and written back once per pixel; it needs no clearing pass after reset. A low
// m_tready stalls the whole pipeline, so s_tready follows it. Border windows give 255 with
// tuser low. A width or height register write restarts the frame at row 0, column 0.
`default_nettype none
module triple_3x3_blur_filter
  import tbf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] box_value, [15:8] gauss_value, [23:16] weighted_value
  output logic             m_tuser,   // [0] window_full
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [11:0]   image_width;
  logic [15:0]   image_height;
  logic [CW:0]   w_use;
  logic [15:0]   h_use;
  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [CW:0]   col_inc;
  logic          accept;
  logic          en;
  logic          cfg_hit;
  logic          full_now;

  logic          s1_valid;
  logic          s1_full;
  logic [7:0]    s1_pixel;
  logic [CW-1:0] s1_addr;
  logic [15:0]   rd_data;
  logic [15:0]   line_mem [MAX_WIDTH];

  logic [7:0]    taps [TAPS];
  tbf_ctl_t      s2_ctl;
  tbf_ctl_t      out_ctl;
  logic [7:0]    box_value;
  logic [7:0]    gauss_value;
  logic [7:0]    weighted_value;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign accept    = s_tvalid && s_tready;
  assign cfg_hit   = cfg_valid && (cfg_index == 8'(REG_WIDTH) || cfg_index == 8'(REG_HEIGHT));

  always_comb begin
    if (image_width < 12'd3) begin
      w_use = (CW+1)'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_use = (CW+1)'(MAX_WIDTH);
    end else begin
      w_use = (CW+1)'(image_width);
    end
    h_use = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  assign col_inc  = {1'b0, col} + 1'b1;
  assign full_now = (row >= 16'd2) && (col >= CW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd512;
      image_height <= 16'd512;
    end else if (cfg_valid) begin
      if (cfg_index == 8'(REG_WIDTH)) begin
        image_width <= cfg_data[11:0];
      end else if (cfg_index == 8'(REG_HEIGHT)) begin
        image_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= w_use) begin
        col <= '0;
        row <= (row + 16'd1 >= h_use) ? 16'd0 : row + 16'd1;
      end else begin
        col <= col_inc[CW-1:0];
      end
    end
  end

  // line store: [15:8] two rows above, [7:0] one row above
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data <= line_mem[col];
      if (s1_valid) begin
        line_mem[s1_addr] <= {rd_data[7:0], s1_pixel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pixel <= s_tdata;
      s1_addr  <= col;
      s1_full  <= full_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        taps[k] <= '0;
      end
      s2_ctl <= '0;
    end else if (en) begin
      s2_ctl.valid <= s1_valid;
      s2_ctl.full  <= s1_full;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          taps[r*3]   <= taps[r*3+1];
          taps[r*3+1] <= taps[r*3+2];
        end
        taps[2] <= rd_data[15:8];
        taps[5] <= rd_data[7:0];
        taps[8] <= s1_pixel;
      end
    end
  end

  tbf_kernel u_kernel (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_ctl         (s2_ctl),
    .taps           (taps),
    .out_ctl        (out_ctl),
    .box_value      (box_value),
    .gauss_value    (gauss_value),
    .weighted_value (weighted_value)
  );

  assign m_tvalid = out_ctl.valid;
  assign m_tuser  = out_ctl.full;
  assign m_tdata  = {weighted_value, gauss_value, box_value};

  a_border_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 24'hFFFFFF)
    else $error("border result not 255");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> box_value <= 8'd252 && gauss_value <= 8'd247 &&
                            weighted_value <= 8'd251)
    else $error("blur sum out of range");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < w_use || $past(cfg_hit))
    else $error("column beyond width");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("transfer lost at line-store stage");

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking stream testbench for the triple 3x3 blur filter.
`timescale 1ns / 1ps
module testbench;
  import tbf_pkg::*;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_TARGET = 330;
  localparam logic [7:0] REG_IDX_WIDTH = 8'(REG_WIDTH);
  localparam logic [7:0] REG_IDX_HEIGHT = 8'(REG_HEIGHT);
  localparam logic [7:0] REG_IDX_SPARE = 8'd2;
  localparam int unsigned KERNEL_GAUSS [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
  localparam int unsigned KERNEL_WEIGHT [9] = '{2, 3, 2, 3, 5, 3, 2, 3, 2};

  typedef struct packed {
    logic [7:0] box;
    logic [7:0] gauss;
    logic [7:0] weighted;
    logic       full;
  } blur_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = 8'd0;
  logic [15:0] cfg_data = 16'd0;

  triple_3x3_blur_filter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // filter state mirror
  logic [11:0] width_reg = 12'd512;
  logic [15:0] height_reg = 16'd512;
  logic [7:0] line_a [MAX_W] = '{default: 8'd0};
  logic [7:0] line_b [MAX_W] = '{default: 8'd0};
  logic [7:0] taps [9] = '{default: 8'd0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  logic [7:0] pixel_backlog [$];
  blur_t blur_expected [$];
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 84;
  int unsigned pixels_in = 0;
  int unsigned full_windows = 0;
  int unsigned settings_run = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned eff_width();
    return (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : int'(height_reg);
  endfunction

  function automatic blur_t blur_window(input logic [7:0] pix);
    int unsigned s_box, s_gauss, s_wtd;
    logic [7:0] up1, up2;
    blur_t r;
    s_box = 0;
    s_gauss = 0;
    s_wtd = 0;
    up1 = line_a[col_pos];
    up2 = line_b[col_pos];
    for (int k = 0; k < 3; k++) begin
      taps[3*k] = taps[3*k+1];
      taps[3*k+1] = taps[3*k+2];
    end
    taps[2] = up2;
    taps[5] = up1;
    taps[8] = pix;
    line_b[col_pos] = up1;
    line_a[col_pos] = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (int k = 0; k < 9; k++) begin
        s_box += taps[k] / 9;
        s_gauss += (taps[k] * KERNEL_GAUSS[k]) / 16;
        s_wtd += (taps[k] * KERNEL_WEIGHT[k]) / 25;
      end
      r = '{box: s_box[7:0], gauss: s_gauss[7:0], weighted: s_wtd[7:0], full: 1'b1};
      full_windows++;
    end else begin
      r = '{box: BORDER_VALUE, gauss: BORDER_VALUE, weighted: BORDER_VALUE, full: 1'b0};
    end
    col_pos++;
    if (col_pos >= eff_width()) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= eff_height()) row_pos = 0;
    end
    return r;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        blur_expected.push_back(blur_window(s_tdata));
        pixels_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata <= pixel_backlog.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    blur_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{box: m_tdata[7:0], gauss: m_tdata[15:8], weighted: m_tdata[23:16],
                full: m_tuser};
        if (blur_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: %h user %b", m_tdata, m_tuser);
        end else begin
          want = blur_expected.pop_front();
          if (got.box !== want.box || got.gauss !== want.gauss
              || got.weighted !== want.weighted || got.full !== want.full) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: box %0d/%0d gauss %0d/%0d weighted %0d/%0d full %b/%b",
                       full_windows, want.box, got.box, want.gauss, got.gauss,
                       want.weighted, got.weighted, want.full, got.full);
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("triple_3x3_blur_filter: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IDX_WIDTH) begin
      width_reg = val[11:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == REG_IDX_HEIGHT) begin
      height_reg = val;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic frame_setup(input logic [15:0] w, input logic [15:0] h);
    cfg_write(REG_IDX_WIDTH, w);
    cfg_write(REG_IDX_HEIGHT, h);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || s_tvalid || blur_expected.size() != 0);
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: pixel_backlog.push_back(8'd0);
        1: pixel_backlog.push_back(8'd255);
        default: pixel_backlog.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    int unsigned random_pixels, wv, hv, n, pick;
    random_pixels = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // power-on 512x512 frame, start of the first row
    push_random(16);
    wait_drained();

    // 3x3 frames from undersized registers: all white, all black, checkerboard
    frame_setup(16'd0, 16'd0);
    repeat (9) pixel_backlog.push_back(8'd255);
    repeat (9) pixel_backlog.push_back(8'd0);
    for (int i = 0; i < 6; i++) pixel_backlog.push_back((i % 2 == 0) ? 8'd255 : 8'd0);
    wait_drained();
    // unused register index must not restart the frame
    cfg_write(REG_IDX_SPARE, 16'hffff);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 3; i++) pixel_backlog.push_back((i % 2 == 0) ? 8'd255 : 8'd0);
    wait_drained();

    // oversized width and tallest frame, start of the first row
    frame_setup(16'hfff, 16'hffff);
    push_random(16);
    wait_drained();
    frame_setup(16'(MAX_W), 16'd3);
    push_random(24);
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 23;
    while (random_pixels < RANDOM_TARGET) begin
      if (random_pixels >= RANDOM_TARGET / 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        frame_setup(16'(wv), 16'(hv));
      end else begin
        if (pick < 8) cfg_write(REG_IDX_WIDTH, 16'(wv));
        else if (pick < 9) cfg_write(REG_IDX_HEIGHT, 16'(hv));
        else cfg_write(8'($urandom_range(2, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        settings_run++;
      end
      n = $urandom_range(1, 2) * eff_width() * eff_height()
          + $urandom_range(0, 2 * eff_width());
      push_random(n);
      random_pixels += n;
      wait_drained();
    end

    repeat (16) @(posedge clk);
    $display("ran %0d pixels over %0d register settings, %0d full windows",
             pixels_in, settings_run, full_windows);
    if (errors == 0) begin
      $display("triple_3x3_blur_filter: match");
    end else begin
      $display("%0d failed checks", errors);
      $display("triple_3x3_blur_filter: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tbf_pkg.sv
rtl/tbf_kernel.sv
rtl/triple_3x3_blur_filter.sv
test/testbench.sv
